// ===== src/csl_pkg.sv =====
// Shared types and constants for the C subset lexer.
`default_nettype none
package csl_pkg;

    localparam int MAX_INPUT_LEN = 65536;
    localparam int POS_W         = $clog2(MAX_INPUT_LEN + 1);
    localparam int MAX_RESULTS   = 3;
    localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W         = $clog2(MAX_RESULTS);

    localparam logic [3:0] KIND_PUNCT  = 4'd0;
    localparam logic [3:0] KIND_RETURN = 4'd1;
    localparam logic [3:0] KIND_IF     = 4'd2;
    localparam logic [3:0] KIND_ELSE   = 4'd3;
    localparam logic [3:0] KIND_WHILE  = 4'd4;
    localparam logic [3:0] KIND_FOR    = 4'd5;
    localparam logic [3:0] KIND_IDENT  = 4'd6;
    localparam logic [3:0] KIND_NUM    = 4'd7;
    localparam logic [3:0] KIND_EOF    = 4'd8;
    localparam logic [3:0] KIND_ERROR  = 4'd9;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start_pos;
        logic [15:0] token_length;
        logic [31:0] number_value;
        logic        value_overflow;
        logic [15:0] op_text;
        logic        last_token;
    } tok_t;

    typedef struct packed {
        tok_t [MAX_RESULTS-1:0] recs;
        logic [CNT_W-1:0]       count;
    } batch_t;

endpackage
`default_nettype wire

// ===== src/csl_core.sv =====
// Lexer state and combinational step logic producing up to three tokens per byte.
`default_nettype none
module csl_core
    import csl_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       take,
    input  wire logic [7:0] ch,
    input  wire logic       end_of_input,
    output batch_t          batch
);

    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_WORD = 2'd1;
    localparam logic [1:0] PEND_NUM  = 2'd2;
    localparam logic [1:0] PEND_OP   = 2'd3;

    localparam logic [2:0] CL_SPACE   = 3'd0;
    localparam logic [2:0] CL_ALPHA   = 3'd1;
    localparam logic [2:0] CL_DIGIT   = 3'd2;
    localparam logic [2:0] CL_OPSTART = 3'd3;
    localparam logic [2:0] CL_PUNCT   = 3'd4;
    localparam logic [2:0] CL_BAD     = 3'd5;

    localparam logic [15:0] LEN_SAT  = 16'hFFFF;
    localparam logic [15:0] HEAD_LEN = 16'd6;

    function automatic logic [2:0] classify(input logic [7:0] c);
        priority if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) return CL_SPACE;
        else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_")
            return CL_ALPHA;
        else if (c >= "0" && c <= "9") return CL_DIGIT;
        else if (c == "=" || c == "!" || c == "<" || c == ">") return CL_OPSTART;
        else if (c == "+" || c == "-" || c == "*" || c == "/" || c == "(" || c == ")" ||
                 c == ";" || c == "{" || c == "}" || c == "," || c == "&")
            return CL_PUNCT;
        else return CL_BAD;
    endfunction

    function automatic logic [3:0] word_kind(input logic [47:0] head,
                                             input logic [15:0] len);
        priority if (len == 16'd6 && head == 48'h72657475726E) return KIND_RETURN;
        else if (len == 16'd2 && head == 48'h6966) return KIND_IF;
        else if (len == 16'd4 && head == 48'h656C7365) return KIND_ELSE;
        else if (len == 16'd5 && head == 48'h7768696C65) return KIND_WHILE;
        else if (len == 16'd3 && head == 48'h666F72) return KIND_FOR;
        else return KIND_IDENT;
    endfunction

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [1:0]       pend_reg, pend_next;
    logic [POS_W-1:0] tstart_reg, tstart_next;
    logic [15:0]      tlen_reg, tlen_next;
    logic [31:0]      acc_reg, acc_next;
    logic             ovf_reg, ovf_next;
    logic [47:0]      head_reg, head_next;
    logic [7:0]       opb_reg, opb_next;
    logic             skip_reg, skip_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            pend_reg   <= PEND_NONE;
            tstart_reg <= '0;
            tlen_reg   <= '0;
            acc_reg    <= '0;
            ovf_reg    <= 1'b0;
            head_reg   <= '0;
            opb_reg    <= '0;
            skip_reg   <= 1'b0;
        end else if (take) begin
            pos_reg    <= pos_next;
            pend_reg   <= pend_next;
            tstart_reg <= tstart_next;
            tlen_reg   <= tlen_next;
            acc_reg    <= acc_next;
            ovf_reg    <= ovf_next;
            head_reg   <= head_next;
            opb_reg    <= opb_next;
            skip_reg   <= skip_next;
        end
    end

    always_comb begin
        logic [2:0]       cls;
        logic             used;
        logic [CNT_W-1:0] n;
        tok_t             t;
        logic [35:0]      prod;
        logic [POS_W-1:0] pos_inc;

        cls = (pos_reg >= POS_W'(MAX_INPUT_LEN)) ? CL_BAD : classify(ch);
        used = 1'b0;
        t = '0;
        n = '0;
        batch.recs = '0;
        pos_inc = pos_reg + POS_W'(1);
        prod = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + {32'b0, ch[3:0]};

        pend_next   = pend_reg;
        tstart_next = tstart_reg;
        tlen_next   = tlen_reg;
        acc_next    = acc_reg;
        ovf_next    = ovf_reg;
        head_next   = head_reg;
        opb_next    = opb_reg;
        skip_next   = skip_reg;
        pos_next    = pos_reg;

        if (!skip_reg) begin
            t = '0;
            // close the pending token unless this byte extends it
            unique case (pend_reg)
                PEND_WORD: begin
                    if (cls == CL_ALPHA || cls == CL_DIGIT) begin
                        if (tlen_reg < HEAD_LEN) head_next = {head_reg[39:0], ch};
                        if (tlen_reg < LEN_SAT) tlen_next = tlen_reg + 16'd1;
                        used = 1'b1;
                    end else begin
                        t.kind = word_kind(head_reg, tlen_reg);
                        t.start_pos = tstart_reg[15:0];
                        t.token_length = tlen_reg;
                        batch.recs[n[IDX_W-1:0]] = t;
                        n = n + CNT_W'(1);
                        pend_next = PEND_NONE;
                    end
                end
                PEND_NUM: begin
                    if (cls == CL_DIGIT) begin
                        acc_next = prod[31:0];
                        if (|prod[35:32]) ovf_next = 1'b1;
                        if (tlen_reg < LEN_SAT) tlen_next = tlen_reg + 16'd1;
                        used = 1'b1;
                    end else begin
                        t.kind = KIND_NUM;
                        t.start_pos = tstart_reg[15:0];
                        t.token_length = tlen_reg;
                        t.number_value = acc_reg;
                        t.value_overflow = ovf_reg;
                        batch.recs[n[IDX_W-1:0]] = t;
                        n = n + CNT_W'(1);
                        pend_next = PEND_NONE;
                    end
                end
                PEND_OP: begin
                    t.start_pos = tstart_reg[15:0];
                    if (cls == CL_OPSTART && ch == "=") begin
                        t.kind = KIND_PUNCT;
                        t.token_length = 16'd2;
                        t.op_text = {opb_reg, ch};
                        used = 1'b1;
                    end else if (opb_reg == "!") begin
                        // lone bang: error, and this byte is skipped with the rest
                        t.kind = KIND_ERROR;
                        t.token_length = 16'd1;
                        t.op_text = {opb_reg, 8'h00};
                        skip_next = 1'b1;
                        used = 1'b1;
                    end else begin
                        t.kind = KIND_PUNCT;
                        t.token_length = 16'd1;
                        t.op_text = {opb_reg, 8'h00};
                    end
                    batch.recs[n[IDX_W-1:0]] = t;
                    n = n + CNT_W'(1);
                    pend_next = PEND_NONE;
                end
                default: ;
            endcase

            if (pend_next == PEND_NONE) begin
                tlen_next = '0;
                acc_next  = '0;
                ovf_next  = 1'b0;
                head_next = '0;
                opb_next  = '0;
            end

            if (!used) begin
                t = '0;
                t.start_pos = pos_reg[15:0];
                t.token_length = 16'd1;
                t.op_text = {ch, 8'h00};
                unique case (cls)
                    CL_SPACE: ;
                    CL_ALPHA: begin
                        pend_next   = PEND_WORD;
                        tstart_next = pos_reg;
                        head_next   = {40'b0, ch};
                        tlen_next   = 16'd1;
                    end
                    CL_DIGIT: begin
                        pend_next   = PEND_NUM;
                        tstart_next = pos_reg;
                        acc_next    = {28'b0, ch[3:0]};
                        tlen_next   = 16'd1;
                    end
                    CL_OPSTART: begin
                        pend_next   = PEND_OP;
                        tstart_next = pos_reg;
                        tlen_next   = 16'd1;
                        opb_next    = ch;
                    end
                    CL_PUNCT: begin
                        t.kind = KIND_PUNCT;
                        batch.recs[n[IDX_W-1:0]] = t;
                        n = n + CNT_W'(1);
                    end
                    default: begin
                        t.kind = KIND_ERROR;
                        batch.recs[n[IDX_W-1:0]] = t;
                        n = n + CNT_W'(1);
                        skip_next = 1'b1;
                    end
                endcase
            end
        end

        if (end_of_input) begin
            t = '0;
            if (!skip_next) begin
                unique case (pend_next)
                    PEND_WORD: begin
                        t.kind = word_kind(head_next, tlen_next);
                        t.start_pos = tstart_next[15:0];
                        t.token_length = tlen_next;
                    end
                    PEND_NUM: begin
                        t.kind = KIND_NUM;
                        t.start_pos = tstart_next[15:0];
                        t.token_length = tlen_next;
                        t.number_value = acc_next;
                        t.value_overflow = ovf_next;
                    end
                    PEND_OP: begin
                        t.kind = (opb_next == "!") ? KIND_ERROR : KIND_PUNCT;
                        t.start_pos = tstart_next[15:0];
                        t.token_length = 16'd1;
                        t.op_text = {opb_next, 8'h00};
                    end
                    default: ;
                endcase
                if (pend_next != PEND_NONE) begin
                    batch.recs[n[IDX_W-1:0]] = t;
                    n = n + CNT_W'(1);
                end
            end
            t = '0;
            t.kind = KIND_EOF;
            t.start_pos = pos_inc[15:0];
            batch.recs[n[IDX_W-1:0]] = t;
            n = n + CNT_W'(1);
            // return to reset so a new text may follow
            pos_next    = '0;
            pend_next   = PEND_NONE;
            tstart_next = '0;
            tlen_next   = '0;
            acc_next    = '0;
            ovf_next    = 1'b0;
            head_next   = '0;
            opb_next    = '0;
            skip_next   = 1'b0;
        end else if (pos_reg < POS_W'(MAX_INPUT_LEN)) begin
            pos_next = pos_inc;
        end

        if (n != '0) batch.recs[IDX_W'(n - CNT_W'(1))].last_token = 1'b1;
        batch.count = n;
    end

endmodule
`default_nettype wire

// ===== src/csl_out.sv =====
// Result register: holds one byte's batch of tokens and hands them out one beat at a time.
`default_nettype none
module csl_out
    import csl_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   s_valid,
    output logic        s_ready,
    input  wire batch_t batch,
    output logic        m_valid,
    input  wire logic   m_ready,
    output tok_t        m_tok
);

    tok_t [MAX_RESULTS-1:0] recs_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       idx_reg;
    logic [CNT_W-1:0]       idx_inc;
    logic                   load;

    assign idx_inc = idx_reg + CNT_W'(1);
    assign m_valid = (idx_reg != cnt_reg);
    // take a new byte when no token is waiting or while the last token of the batch leaves
    assign s_ready = !m_valid || (m_ready && idx_inc == cnt_reg);
    assign load    = s_valid && s_ready;
    assign m_tok   = recs_reg[idx_reg[IDX_W-1:0]];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end else if (load) begin
            cnt_reg <= batch.count;
            idx_reg <= '0;
        end else if (m_valid && m_ready) begin
            idx_reg <= idx_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) recs_reg <= batch.recs;
    end

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= cnt_reg)
        else $error("token index beyond batch count");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load && batch.count != '0 |=> m_valid)
        else $error("loaded batch not presented");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(idx_reg) && m_valid)
        else $error("stalled token moved");

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_tok.last_token == (idx_inc == cnt_reg)))
        else $error("last_token flag not on final token of batch");

endmodule
`default_nettype wire

// ===== src/c_subset_lexer_top.sv =====
// Top level of the streaming C subset lexer.
// Usage:
//   Input channel s_*: one source byte per beat (s_ch) with s_end_of_input
//   marking the final byte of a text. Output channel m_*: one token per beat.
//   Each byte yields zero to three tokens (close of a pending token, its own
//   punctuator or error, and EOF on the final byte); m_last_token marks the
//   final token caused by a byte.
// Latency: a byte's first token is on m_* the cycle after the byte is taken.
// Throughput: while m_ready is high a byte that yields zero or one token is taken every
//   cycle; a byte yielding more tokens holds the result register until they have all
//   left, the next byte being taken in the cycle its last token leaves. Sustained rate is
//   set by the three-entry result register draining one token per cycle while m_ready is high.
// Stall: while m_ready is low the current token holds and s_ready drops once
//   the result register holds tokens not yet taken.
// Reset: aresetn (synchronous, active low) clears the position counter, any
//   pending token, the error-skip flag and drops m_valid. After an EOF token
//   the lexer is back in its reset state, ready for a new text.
`default_nettype none
module c_subset_lexer_top
    import csl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_ch,
    input  wire logic        s_end_of_input,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_token_kind,
    output logic [15:0]      m_start_pos,
    output logic [15:0]      m_token_length,
    output logic [31:0]      m_number_value,
    output logic             m_value_overflow,
    output logic [15:0]      m_op_text,
    output logic             m_last_token
);

    batch_t batch;
    tok_t   tok;

    csl_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .take         (s_valid && s_ready),
        .ch           (s_ch),
        .end_of_input (s_end_of_input),
        .batch        (batch)
    );

    csl_out u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .batch   (batch),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_tok   (tok)
    );

    assign m_token_kind     = tok.kind;
    assign m_start_pos      = tok.start_pos;
    assign m_token_length   = tok.token_length;
    assign m_number_value   = tok.number_value;
    assign m_value_overflow = tok.value_overflow;
    assign m_op_text        = tok.op_text;
    assign m_last_token     = tok.last_token;

endmodule
`default_nettype wire

// ===== tb/sv/lexer_token_check.sv =====
// Token scoreboard for the C subset lexer: predicts tokens from accepted bytes and checks them.
module lexer_token_check
    import csl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [7:0]  s_ch,
    input  wire logic        s_end_of_input,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [3:0]  m_token_kind,
    input  wire logic [15:0] m_start_pos,
    input  wire logic [15:0] m_token_length,
    input  wire logic [31:0] m_number_value,
    input  wire logic        m_value_overflow,
    input  wire logic [15:0] m_op_text,
    input  wire logic        m_last_token,
    output int               fail_count,
    output int               pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {OPEN_NONE, OPEN_WORD, OPEN_NUM, OPEN_OP} open_e;
    typedef enum logic [2:0] {
        CC_SPACE, CC_ALPHA, CC_DIGIT, CC_OPSTART, CC_PUNCT, CC_BAD
    } char_class_e;

    localparam logic [47:0] KW_RETURN = "return";
    localparam logic [47:0] KW_IF     = "if";
    localparam logic [47:0] KW_ELSE   = "else";
    localparam logic [47:0] KW_WHILE  = "while";
    localparam logic [47:0] KW_FOR    = "for";

    // lexer state as the predictor sees it
    int unsigned pos_q;
    open_e       open_tok;
    logic [15:0] tok_start;
    int unsigned tok_len;
    logic [31:0] num_acc;
    logic        num_ovf;
    logic [47:0] word_head;
    logic [7:0]  op_byte;
    logic        skipping;

    tok_t expected_tokens[$];
    tok_t step_toks[$];

    function automatic char_class_e class_of(logic [7:0] c);
        if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) return CC_SPACE;
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") return CC_ALPHA;
        if (c >= "0" && c <= "9") return CC_DIGIT;
        if (c == "=" || c == "!" || c == "<" || c == ">") return CC_OPSTART;
        case (c)
            "+", "-", "*", "/", "(", ")", ";", "{", "}", ",", "&": return CC_PUNCT;
            default: return CC_BAD;
        endcase
    endfunction

    function automatic void push_tok(logic [3:0] kind, logic [15:0] start, int unsigned len,
                                     logic [31:0] val, logic ovf, logic [15:0] op);
        tok_t t;
        t.kind           = kind;
        t.start_pos      = start;
        t.token_length   = 16'(len);
        t.number_value   = val;
        t.value_overflow = ovf;
        t.op_text        = op;
        t.last_token     = 1'b0;
        step_toks.push_back(t);
    endfunction

    function automatic void clear_open();
        open_tok  = OPEN_NONE;
        tok_len   = 0;
        num_acc   = '0;
        num_ovf   = 1'b0;
        word_head = '0;
        op_byte   = '0;
    endfunction

    function automatic void restart();
        pos_q     = 0;
        tok_start = '0;
        skipping  = 1'b0;
        clear_open();
    endfunction

    function automatic void add_letter(logic [7:0] c);
        // only the first six bytes matter for keyword matching
        if (tok_len < 6) word_head = {word_head[39:0], c};
        if (tok_len < 65535) tok_len++;
    endfunction

    // Close whatever token is open; a lone bang turns into an error.
    function automatic void close_open();
        logic [3:0] kind;
        case (open_tok)
            OPEN_WORD: begin
                kind = KIND_IDENT;
                if (tok_len == 6 && word_head == KW_RETURN) kind = KIND_RETURN;
                if (tok_len == 2 && word_head == KW_IF)     kind = KIND_IF;
                if (tok_len == 4 && word_head == KW_ELSE)   kind = KIND_ELSE;
                if (tok_len == 5 && word_head == KW_WHILE)  kind = KIND_WHILE;
                if (tok_len == 3 && word_head == KW_FOR)    kind = KIND_FOR;
                push_tok(kind, tok_start, tok_len, '0, 1'b0, '0);
            end
            OPEN_NUM: push_tok(KIND_NUM, tok_start, tok_len, num_acc, num_ovf, '0);
            OPEN_OP: begin
                if (op_byte == "!") begin
                    push_tok(KIND_ERROR, tok_start, 1, '0, 1'b0, {op_byte, 8'h00});
                    skipping = 1'b1;
                end else begin
                    push_tok(KIND_PUNCT, tok_start, 1, '0, 1'b0, {op_byte, 8'h00});
                end
            end
            default: ;
        endcase
        clear_open();
    endfunction

    function automatic void lex_byte(logic [7:0] c, logic eoi);
        int unsigned pos;
        char_class_e cls;
        logic        taken;
        logic [63:0] v;
        pos   = pos_q;
        cls   = (pos >= MAX_INPUT_LEN) ? CC_BAD : class_of(c);
        taken = 1'b0;
        step_toks.delete();
        if (!skipping) begin
            case (open_tok)
                OPEN_WORD: begin
                    if (cls == CC_ALPHA || cls == CC_DIGIT) begin
                        add_letter(c);
                        taken = 1'b1;
                    end else begin
                        close_open();
                    end
                end
                OPEN_NUM: begin
                    if (cls == CC_DIGIT) begin
                        v = 64'(num_acc) * 64'd10 + 64'(c - 8'h30);
                        if (v[63:32] != '0) num_ovf = 1'b1;
                        num_acc = v[31:0];
                        if (tok_len < 65535) tok_len++;
                        taken = 1'b1;
                    end else begin
                        close_open();
                    end
                end
                OPEN_OP: begin
                    if (cls == CC_OPSTART && c == "=") begin
                        push_tok(KIND_PUNCT, tok_start, 2, '0, 1'b0, {op_byte, c});
                        clear_open();
                        taken = 1'b1;
                    end else begin
                        close_open();
                        // the byte after a lone bang is swallowed by the skip
                        if (skipping) taken = 1'b1;
                    end
                end
                default: ;
            endcase
            if (!taken && !skipping) begin
                case (cls)
                    CC_ALPHA: begin
                        open_tok  = OPEN_WORD;
                        tok_start = 16'(pos);
                        add_letter(c);
                    end
                    CC_DIGIT: begin
                        open_tok  = OPEN_NUM;
                        tok_start = 16'(pos);
                        num_acc   = 32'(c - 8'h30);
                        tok_len   = 1;
                    end
                    CC_OPSTART: begin
                        open_tok  = OPEN_OP;
                        tok_start = 16'(pos);
                        tok_len   = 1;
                        op_byte   = c;
                    end
                    CC_PUNCT: push_tok(KIND_PUNCT, 16'(pos), 1, '0, 1'b0, {c, 8'h00});
                    CC_BAD: begin
                        push_tok(KIND_ERROR, 16'(pos), 1, '0, 1'b0, {c, 8'h00});
                        skipping = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
        if (eoi) begin
            if (!skipping) close_open();
            push_tok(KIND_EOF, 16'(pos + 1), 0, '0, 1'b0, '0);
            restart();
        end else if (pos_q < MAX_INPUT_LEN) begin
            pos_q++;
        end
        if (step_toks.size() != 0) step_toks[step_toks.size() - 1].last_token = 1'b1;
        foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : scoreboard
        tok_t want;
        if (!aresetn) begin
            restart();
            expected_tokens.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_tokens.size() == 0) begin
                    $error("token with none expected: kind %0d at %0d",
                           m_token_kind, m_start_pos);
                    fail_count++;
                end else begin
                    want = expected_tokens.pop_front();
                    check_field("token_kind", want.kind, m_token_kind);
                    check_field("start_pos", want.start_pos, m_start_pos);
                    check_field("token_length", want.token_length, m_token_length);
                    check_field("number_value", want.number_value, m_number_value);
                    check_field("value_overflow", want.value_overflow, m_value_overflow);
                    check_field("op_text", want.op_text, m_op_text);
                    check_field("last_token", want.last_token, m_last_token);
                end
            end
            if (s_valid && s_ready) lex_byte(s_ch, s_end_of_input);
        end
        pending_count <= expected_tokens.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the lexer testbench: clock, reset, source text stimulus, receiver stalls and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD      = 20;
    localparam int RANDOM_ITEMS    = 400;
    localparam int HOLD_OFF_CYCLES = 150;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [7:0]  s_ch           = 8'h00;
    logic        s_end_of_input = 1'b0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [3:0]  m_token_kind;
    logic [15:0] m_start_pos;
    logic [15:0] m_token_length;
    logic [31:0] m_number_value;
    logic        m_value_overflow;
    logic [15:0] m_op_text;
    logic        m_last_token;
    int          fail_count;
    int          pending_count;

    logic [7:0] text_buf[$];
    int         burst_left    = 0;
    bit         steady        = 1'b0;
    bit         hold_off_req  = 1'b0;
    bit         hold_off_done = 1'b0;
    int         random_items  = 0;

    string word_start = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string word_chars = "abcdefrilnostuwxyzEFILRW_0123456789";
    string digits     = "0123456789";
    string puncts     = "+-*/();{},&";
    string spaces     = " \t\n\v\f\r";
    string kw_words[5]   = '{"return", "if", "else", "while", "for"};
    string near_words[6] = '{"retur", "returns", "iff", "els", "_for", "While"};
    string big_nums[3]   = '{"4294967295", "4294967296", "99999999999999999999"};
    string op_words[8]   = '{"==", "!=", "<=", ">=", "=", "<", ">", "!"};

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    c_subset_lexer_top i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_ch             (s_ch),
        .s_end_of_input   (s_end_of_input),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_token_kind     (m_token_kind),
        .m_start_pos      (m_start_pos),
        .m_token_length   (m_token_length),
        .m_number_value   (m_number_value),
        .m_value_overflow (m_value_overflow),
        .m_op_text        (m_op_text),
        .m_last_token     (m_last_token)
    );

    lexer_token_check i_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_ch             (s_ch),
        .s_end_of_input   (s_end_of_input),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_token_kind     (m_token_kind),
        .m_start_pos      (m_start_pos),
        .m_token_length   (m_token_length),
        .m_number_value   (m_number_value),
        .m_value_overflow (m_value_overflow),
        .m_op_text        (m_op_text),
        .m_last_token     (m_last_token),
        .fail_count       (fail_count),
        .pending_count    (pending_count)
    );

    function automatic logic [7:0] pick_char(string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endfunction

    function automatic void put_token();
        int n;
        case ($urandom_range(0, 9))
            0: put_str(kw_words[$urandom_range(0, 4)]);
            1: put_str(near_words[$urandom_range(0, 5)]);
            2, 3: begin
                text_buf.push_back(pick_char(word_start));
                n = $urandom_range(0, 7);
                repeat (n) text_buf.push_back(pick_char(word_chars));
            end
            4, 5: begin
                if ($urandom_range(0, 4) == 0) begin
                    put_str(big_nums[$urandom_range(0, 2)]);
                end else begin
                    n = $urandom_range(1, 12);
                    repeat (n) text_buf.push_back(pick_char(digits));
                end
            end
            6: put_str(op_words[$urandom_range(0, 7)]);
            7, 8: text_buf.push_back(pick_char(puncts));
            default: text_buf.push_back(pick_char(spaces));
        endcase
    endfunction

    // Tokens, glued together or split by whitespace, with a rare stray byte.
    function automatic void build_text();
        int ntok;
        int nsp;
        ntok = $urandom_range(1, 12);
        repeat (ntok) begin
            if ($urandom_range(0, 29) == 0) text_buf.push_back(8'($urandom_range(0, 255)));
            put_token();
            if ($urandom_range(0, 1) == 1) begin
                nsp = $urandom_range(1, 3);
                repeat (nsp) text_buf.push_back(pick_char(spaces));
            end
        end
    endfunction

    task automatic send_beat(input logic [7:0] c, input logic eoi);
        int gap;
        if (!steady) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                repeat (gap) begin
                    @(negedge aclk);
                    s_valid <= 1'b0;
                end
            end
            burst_left--;
        end
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_ch           <= c;
        s_end_of_input <= eoi;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++) send_beat(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
    endtask

    initial begin : stimulus
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // overflowing number, then a lone bang that starts the skip
        put_str("for 4294967296!x");
        send_text();
        // final byte closes an identifier, emits its own punctuator and the EOF
        put_str("x;");
        send_text();
        text_buf.push_back("a");
        text_buf.push_back(8'h00);
        text_buf.push_back("b");
        send_text();
        text_buf.push_back(8'hFF);
        send_text();
        put_str("<");
        send_text();
        put_str(" ");
        send_text();
        wait_drained();

        while (random_items < RANDOM_ITEMS) begin
            if (!hold_off_req && random_items >= RANDOM_ITEMS / 3) begin
                // keep offering while the receiver holds off so the block backs up
                hold_off_req = 1'b1;
                steady       = 1'b1;
                repeat (40) text_buf.push_back(";");
                random_items += text_buf.size();
                send_text();
                steady = 1'b0;
            end
            build_text();
            random_items += text_buf.size();
            send_text();
            if ($urandom_range(0, 9) == 0) wait_drained();
        end
        wait_drained();
        repeat (20) @(negedge aclk);

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : receiver
        int seg_left;
        int mode;
        seg_left = 0;
        mode     = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req && !hold_off_done) begin
                m_ready <= 1'b0;
                hold_off_done = 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(8, 60);
                end
                seg_left--;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    2: m_ready <= ($urandom_range(0, 2) == 0);
                    default: m_ready <= ~m_ready;
                endcase
            end
        end
    end

    // time limit for a few hundred beats under the slowest stalls, with a wide margin
    initial begin : watchdog
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
